[rtl/rpd_pkg.sv]
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants of the radio packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int PKT_BYTES   = 32;
  localparam int PKT_BITS    = PKT_BYTES * 8;
  localparam int BYTE_IDX_W  = $clog2(PKT_BYTES);
  localparam int QUEUE_DEPTH = 2;

  // bytes 0..7 of a header, byte 0 in the low bits
  localparam logic [63:0] SYNC_MARK = 64'hA08C_15FF_00A8_39AC;

  localparam logic [7:0] HDR_TEXT = 8'd1;
  localparam logic [7:0] HDR_FILE = 8'd2;

  localparam logic [5:0] TAIL_FULL = 6'd32;
  localparam logic [8:0] NAME_SAT  = 9'd511;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TEXT,
    MODE_NAME,
    MODE_FILE
  } mode_t;

  // one packet worth of work for the emit side
  typedef struct packed {
    logic [PKT_BITS-1:0]   data;
    logic [1:0]            kind;
    logic [BYTE_IDX_W-1:0] cnt_m1;
    logic                  obj_end;
    logic                  chk;
    logic                  sum_clear;
    logic [15:0]           expected;
  } job_t;

endpackage

[rtl/rpd_if.sv]
// ----------------------------------------------------------------------------
// rpd_if
// Valid/ready channels of the radio packet deframer.
// ----------------------------------------------------------------------------
interface rpd_packet_if;
  logic        valid;
  logic        ready;
  logic [63:0] packet_word0;
  logic [63:0] packet_word1;
  logic [63:0] packet_word2;
  logic [63:0] packet_word3;

  modport source (output valid, packet_word0, packet_word1, packet_word2, packet_word3,
                  input ready);
  modport sink (input valid, packet_word0, packet_word1, packet_word2, packet_word3,
                output ready);
endinterface

interface rpd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       object_end;
  logic       checksum_ok;
  logic       last;

  modport source (output valid, kind, value, object_end, checksum_ok, last,
                  input ready);
  modport sink (input valid, kind, value, object_end, checksum_ok, last,
                output ready);
endinterface

[rtl/rpd_front.sv]
// ----------------------------------------------------------------------------
// rpd_front
// Takes packets, decodes headers, tracks the text/name/file state and turns
// each data packet that the current mode takes into one emit job.
// ----------------------------------------------------------------------------
module rpd_front
  import rpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rpd_packet_if.sink    packets,
  input  logic          q_full,
  output logic          push,
  output job_t          job
);

  mode_t       mode, mode_next;
  logic [15:0] pages_left, pages_left_next;
  logic [5:0]  tail_count, tail_count_next;
  logic [7:0]  name_length, name_length_next;
  logic [8:0]  name_received, name_received_next;
  logic [15:0] expected_sum, expected_sum_next;
  logic        sum_fresh, sum_fresh_next;

  logic        accept;
  logic        marked;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_tail;
  logic [8:0]  name_gap;
  logic [9:0]  name_adv;
  logic [5:0]  tail_m1;
  logic [8:0]  gap_m1;

  assign packets.ready = !q_full;
  assign accept        = packets.valid && packets.ready;
  assign marked        = (packets.packet_word0 == SYNC_MARK);
  assign hdr_type      = packets.packet_word1[7:0];
  assign hdr_tail      = packets.packet_word1[31:24];
  assign name_gap      = {1'b0, name_length} - name_received;
  assign name_adv      = {1'b0, name_received} + 10'd32;
  assign tail_m1       = tail_count - 6'd1;
  assign gap_m1        = name_gap - 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      pages_left    <= '0;
      tail_count    <= '0;
      name_length   <= '0;
      name_received <= '0;
      expected_sum  <= '0;
      sum_fresh     <= 1'b0;
    end else begin
      mode          <= mode_next;
      pages_left    <= pages_left_next;
      tail_count    <= tail_count_next;
      name_length   <= name_length_next;
      name_received <= name_received_next;
      expected_sum  <= expected_sum_next;
      sum_fresh     <= sum_fresh_next;
    end
  end

  always_comb begin
    mode_next          = mode;
    pages_left_next    = pages_left;
    tail_count_next    = tail_count;
    name_length_next   = name_length;
    name_received_next = name_received;
    expected_sum_next  = expected_sum;
    sum_fresh_next     = sum_fresh;
    push               = 1'b0;
    job.data      = {packets.packet_word3, packets.packet_word2,
                     packets.packet_word1, packets.packet_word0};
    job.kind      = KIND_TEXT;
    job.cnt_m1    = BYTE_IDX_W'(PKT_BYTES - 1);
    job.obj_end   = 1'b0;
    job.chk       = 1'b0;
    job.sum_clear = 1'b0;
    job.expected  = expected_sum;

    if (accept) begin
      if (marked) begin
        if (hdr_type == HDR_TEXT || hdr_type == HDR_FILE) begin
          pages_left_next = {packets.packet_word1[15:8], packets.packet_word1[23:16]};
          // tail of zero or above a full packet means a full packet
          if (hdr_tail == 8'd0 || hdr_tail > 8'd32) begin
            tail_count_next = TAIL_FULL;
          end else begin
            tail_count_next = hdr_tail[5:0];
          end
          if (hdr_type == HDR_TEXT) begin
            mode_next = MODE_TEXT;
          end else begin
            mode_next          = MODE_NAME;
            name_length_next   = packets.packet_word1[39:32];
            name_received_next = '0;
            expected_sum_next  = {packets.packet_word1[55:48], packets.packet_word1[63:56]};
            sum_fresh_next     = 1'b1;
          end
        end
      end else begin
        unique case (mode)
          MODE_TEXT: begin
            push = 1'b1;
            if (pages_left == 16'd0) begin
              job.kind    = KIND_EMPTY;
              job.data    = '0;
              job.cnt_m1  = '0;
              job.obj_end = 1'b1;
              mode_next   = MODE_IDLE;
            end else begin
              pages_left_next = pages_left - 16'd1;
              if (pages_left == 16'd1) begin
                job.cnt_m1  = tail_m1[BYTE_IDX_W-1:0];
                job.obj_end = 1'b1;
                mode_next   = MODE_IDLE;
              end
            end
          end
          MODE_NAME: begin
            push     = 1'b1;
            job.kind = KIND_NAME;
            if ({1'b0, name_length} > name_received) begin
              if (name_gap <= 9'd32) begin
                job.cnt_m1         = gap_m1[BYTE_IDX_W-1:0];
                job.obj_end        = 1'b1;
                name_received_next = {1'b0, name_length};
                mode_next          = MODE_FILE;
              end else begin
                name_received_next = name_adv[8:0];
              end
            end else if (name_adv >= {1'b0, NAME_SAT}) begin
              // name never completes, counter pins at its ceiling
              name_received_next = NAME_SAT;
            end else begin
              name_received_next = name_adv[8:0];
            end
          end
          MODE_FILE: begin
            if (pages_left != 16'd0) begin
              push            = 1'b1;
              job.kind        = KIND_DATA;
              job.sum_clear   = sum_fresh;
              sum_fresh_next  = 1'b0;
              pages_left_next = pages_left - 16'd1;
              if (pages_left == 16'd1) begin
                job.cnt_m1  = tail_m1[BYTE_IDX_W-1:0];
                job.obj_end = 1'b1;
                job.chk     = 1'b1;
                mode_next   = MODE_IDLE;
              end
            end
          end
          MODE_IDLE: begin
          end
        endcase
      end
    end
  end

endmodule

[rtl/rpd_queue.sv]
// ----------------------------------------------------------------------------
// rpd_queue
// Short job queue between the decode side and the emit side.
// ----------------------------------------------------------------------------
module rpd_queue
  import rpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output job_t rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign nonempty = (fill != '0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/rpd_emit.sv]
// ----------------------------------------------------------------------------
// rpd_emit
// Walks a job one byte per cycle while results is not stalled, keeps the file
// byte sum and drives the registered result channel.
// ----------------------------------------------------------------------------
module rpd_emit
  import rpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_nonempty,
  input  job_t          q_job,
  output logic          pop,
  rpd_result_if.source  results
);

  logic                  busy;
  logic [PKT_BITS-1:0]   data;
  logic [BYTE_IDX_W-1:0] remain;
  logic [1:0]            kind;
  logic                  obj_end;
  logic                  chk;
  logic [15:0]           expected;
  logic [15:0]           sum;

  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic       out_end;
  logic       out_ok;
  logic       out_last;

  logic        emit;
  logic        final_byte;
  logic [7:0]  cur_byte;
  logic [15:0] sum_add;

  assign emit       = busy && (!out_valid || results.ready);
  assign final_byte = (remain == '0);
  assign cur_byte   = data[7:0];
  assign sum_add    = sum + {8'd0, cur_byte};
  // next job loads as the current one hands over its final byte
  assign pop        = q_nonempty && (!busy || (emit && final_byte));

  assign results.valid       = out_valid;
  assign results.kind        = out_kind;
  assign results.value       = out_value;
  assign results.object_end  = out_end;
  assign results.checksum_ok = out_ok;
  assign results.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      sum       <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && final_byte) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (pop && q_job.sum_clear) begin
        sum <= '0;
      end else if (emit && kind == KIND_DATA) begin
        sum <= sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= kind;
      out_value <= cur_byte;
      out_end   <= obj_end && final_byte;
      out_ok    <= chk && final_byte && (sum_add == expected);
      out_last  <= final_byte;
    end
    if (pop) begin
      data     <= q_job.data;
      remain   <= q_job.cnt_m1;
      kind     <= q_job.kind;
      obj_end  <= q_job.obj_end;
      chk      <= q_job.chk;
      expected <= q_job.expected;
    end else if (emit) begin
      data   <= data >> 8;
      remain <= remain - BYTE_IDX_W'(1);
    end
  end

endmodule

[rtl/radio_packet_deframer.sv]
// ----------------------------------------------------------------------------
// radio_packet_deframer
// Splits 32-byte radio packets into typed text, file name and file data bytes.
//
//   channel   dir   width       carries
//   packets   in    4 x 64      one radio packet, byte 0 in packet_word0[7:0]
//   results   out   2+8+1+1+1   kind, value, object_end, checksum_ok, last
//
// A data packet gives up to 32 results, one per cycle while results is not
// stalled, so the emit side sets the packet rate; headers and dropped packets give no job.
// The decode side accepts a packet per cycle while the job queue has room.
// Synchronous reset clears mode, counters and queue; no clearing pass.
// A stall on results holds the output register and backs up into the queue.
// ----------------------------------------------------------------------------
module radio_packet_deframer
  import rpd_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  rpd_packet_if.sink   packets,
  rpd_result_if.source results
);

  logic q_full;
  logic q_nonempty;
  logic push;
  logic pop;
  job_t wr_job;
  job_t rd_job;

  rpd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .packets (packets),
    .q_full  (q_full),
    .push    (push),
    .job     (wr_job)
  );

  rpd_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rd_job   (rd_job)
  );

  rpd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_job      (rd_job),
    .pop        (pop),
    .results    (results)
  );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radio_packet_deframer. Text and file transfers,
// foreign headers and stray packets go in with random gaps. Every byte result
// is checked against a packet-level model of the deframer kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import rpd_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       object_end;
    logic       checksum_ok;
    logic       last;
  } byte_result_t;

  logic clk = 1'b0;
  logic rst;

  rpd_packet_if packets ();
  rpd_result_if results ();

  radio_packet_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .packets (packets),
    .results (results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // deframer state as seen from outside
  mode_t       m_mode      = MODE_IDLE;
  logic [15:0] m_pages     = '0;
  logic [5:0]  m_tail      = '0;
  logic [7:0]  m_name_len  = '0;
  logic [8:0]  m_name_seen = '0;
  logic [15:0] m_sum_hdr   = '0;
  logic [15:0] m_sum_acc   = '0;

  byte_result_t held_result;
  bit           held_valid;
  byte_result_t expected_bytes[$];
  logic [255:0] pending_packets[$];
  int           seq_items = 0;
  int           packets_accepted = 0;
  int           mismatches = 0;

  // last flag is only known once the packet is done, so hold one result back
  function automatic void emit_byte(logic [1:0] kind, logic [7:0] value, logic ends,
                                    logic ok);
    if (held_valid)
      expected_bytes.push_back(held_result);
    held_result = '{kind, value, ends, ok, 1'b0};
    held_valid = 1'b1;
  endfunction

  task automatic deframe_packet(input logic [255:0] pkt);
    logic [7:0] hdr_type;
    logic [7:0] tail_raw;
    logic [7:0] b;
    int         cnt;
    int         i;
    bit         done;
    held_valid = 1'b0;
    if (pkt[63:0] == SYNC_MARK) begin
      hdr_type = pkt[71:64];
      if (hdr_type == HDR_TEXT || hdr_type == HDR_FILE) begin
        m_pages = {pkt[79:72], pkt[87:80]};
        tail_raw = pkt[95:88];
        m_tail = (tail_raw == 8'd0 || tail_raw > 8'd32) ? TAIL_FULL : tail_raw[5:0];
        if (hdr_type == HDR_TEXT) begin
          m_mode = MODE_TEXT;
        end else begin
          m_mode = MODE_NAME;
          m_name_len = pkt[103:96];
          m_name_seen = '0;
          m_sum_hdr = {pkt[119:112], pkt[127:120]};
          m_sum_acc = '0;
        end
      end
    end else begin
      case (m_mode)
        MODE_TEXT: begin
          if (m_pages == 16'd0) begin
            emit_byte(KIND_EMPTY, 8'd0, 1'b1, 1'b0);
            m_mode = MODE_IDLE;
          end else begin
            m_pages = m_pages - 16'd1;
            cnt = (m_pages == 16'd0) ? int'(m_tail) : PKT_BYTES;
            for (i = 0; i < cnt; i++)
              emit_byte(KIND_TEXT, pkt[8*i +: 8], (m_pages == 16'd0) && (i == cnt - 1),
                        1'b0);
            if (m_pages == 16'd0)
              m_mode = MODE_IDLE;
          end
        end
        MODE_NAME: begin
          done = 1'b0;
          for (i = 0; i < PKT_BYTES && !done; i++) begin
            if (m_name_seen != NAME_SAT)
              m_name_seen = m_name_seen + 9'd1;
            if (m_name_seen == {1'b0, m_name_len}) begin
              emit_byte(KIND_NAME, pkt[8*i +: 8], 1'b1, 1'b0);
              m_mode = MODE_FILE;
              done = 1'b1;
            end else begin
              emit_byte(KIND_NAME, pkt[8*i +: 8], 1'b0, 1'b0);
            end
          end
        end
        MODE_FILE: begin
          if (m_pages != 16'd0) begin
            m_pages = m_pages - 16'd1;
            cnt = (m_pages == 16'd0) ? int'(m_tail) : PKT_BYTES;
            for (i = 0; i < cnt; i++) begin
              b = pkt[8*i +: 8];
              m_sum_acc = m_sum_acc + {8'd0, b};
              if (m_pages == 16'd0 && i == cnt - 1)
                emit_byte(KIND_DATA, b, 1'b1, m_sum_acc == m_sum_hdr);
              else
                emit_byte(KIND_DATA, b, 1'b0, 1'b0);
            end
            if (m_pages == 16'd0)
              m_mode = MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
    if (held_valid) begin
      held_result.last = 1'b1;
      expected_bytes.push_back(held_result);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [255:0] random_packet();
    logic [255:0] p;
    for (int k = 0; k < 8; k++)
      p[32*k +: 32] = $urandom;
    if (p[63:0] == SYNC_MARK)
      p[0] = ~p[0];
    return p;
  endfunction

  function automatic logic [255:0] header_packet(logic [7:0] hdr_type, logic [15:0] pages,
                                                 logic [7:0] tail, logic [7:0] name_len,
                                                 logic [15:0] csum);
    logic [255:0] p;
    p = random_packet();
    p[63:0]    = SYNC_MARK;
    p[71:64]   = hdr_type;
    p[87:72]   = {pages[7:0], pages[15:8]};
    p[95:88]   = tail;
    p[103:96]  = name_len;
    p[127:112] = {csum[7:0], csum[15:8]};
    return p;
  endfunction

  function automatic logic [7:0] pick_tail();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return 8'd0;
    if (r < 8)
      return 8'($urandom_range(1, 32));
    return 8'($urandom_range(33, 255));
  endfunction

  task automatic send_text(logic [15:0] pages, logic [7:0] tail, int n_data);
    pending_packets.push_back(header_packet(HDR_TEXT, pages, tail, 8'($urandom),
                                            16'($urandom)));
    for (int k = 0; k < n_data; k++)
      pending_packets.push_back(random_packet());
    seq_items += 1 + n_data;
  endtask

  // data is drawn first so the header can carry a matching checksum
  task automatic send_file(logic [15:0] pages, logic [7:0] tail, logic [7:0] name_len,
                           bit good_sum, int n_data);
    logic [255:0] data_pkts[$];
    logic [15:0]  sum;
    logic [15:0]  csum;
    int           tail_len;
    int           cnt;
    int           n_name;
    tail_len = (tail == 8'd0 || tail > 8'd32) ? PKT_BYTES : int'(tail);
    n_name = (int'(name_len) + PKT_BYTES - 1) / PKT_BYTES;
    sum = '0;
    for (int k = 0; k < n_data; k++) begin
      data_pkts.push_back(random_packet());
      cnt = (k + 1 == int'(pages)) ? tail_len : PKT_BYTES;
      for (int i = 0; i < cnt; i++)
        sum = sum + {8'd0, data_pkts[k][8*i +: 8]};
    end
    csum = good_sum ? sum : sum ^ 16'($urandom_range(1, 65535));
    pending_packets.push_back(header_packet(HDR_FILE, pages, tail, name_len, csum));
    for (int k = 0; k < n_name; k++)
      pending_packets.push_back(random_packet());
    for (int k = 0; k < n_data; k++)
      pending_packets.push_back(data_pkts[k]);
    seq_items += 1 + n_name + n_data;
  endtask

  // ------------------------------------------------------------------ driver

  int           send_gap = 0;
  bit           send_burst = 1'b0;
  int           send_roll;
  logic [255:0] next_packet;

  always @(posedge clk) begin
    if (rst) begin
      packets.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (packets.valid && packets.ready) begin
        deframe_packet({packets.packet_word3, packets.packet_word2,
                        packets.packet_word1, packets.packet_word0});
        packets_accepted++;
      end
      if (!packets.valid || packets.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          packets.valid <= 1'b0;
        end else if (pending_packets.size() != 0) begin
          next_packet = pending_packets.pop_front();
          packets.valid <= 1'b1;
          packets.packet_word0 <= next_packet[63:0];
          packets.packet_word1 <= next_packet[127:64];
          packets.packet_word2 <= next_packet[191:128];
          packets.packet_word3 <= next_packet[255:192];
          if ($urandom_range(0, 24) == 0)
            send_burst = !send_burst;
          send_roll = $urandom_range(0, 99);
          if (send_burst || send_roll < 55)
            send_gap = 0;
          else if (send_roll < 92)
            send_gap = $urandom_range(1, 3);
          else
            send_gap = $urandom_range(6, 40);
        end else begin
          packets.valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  int           stall_left = 0;
  bit           recv_quiet = 1'b0;
  int           recv_roll;
  byte_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 20)
            $display("%0t: unexpected result, expected none, got kind=%0d value=%02h end=%b ok=%b last=%b",
                     $time, results.kind, results.value, results.object_end,
                     results.checksum_ok, results.last);
        end else begin
          want = expected_bytes.pop_front();
          if (results.kind !== want.kind || results.value !== want.value ||
              results.object_end !== want.object_end ||
              results.checksum_ok !== want.checksum_ok || results.last !== want.last) begin
            mismatches++;
            if (mismatches <= 20)
              $display("%0t: result mismatch, expected kind=%0d value=%02h end=%b ok=%b last=%b, got kind=%0d value=%02h end=%b ok=%b last=%b",
                       $time, want.kind, want.value, want.object_end, want.checksum_ok,
                       want.last, results.kind, results.value, results.object_end,
                       results.checksum_ok, results.last);
          end
        end
      end
      if ($urandom_range(0, 299) == 0)
        recv_quiet = !recv_quiet;
      if (stall_left > 0) begin
        stall_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
        recv_roll = $urandom_range(0, 99);
        if (!recv_quiet) begin
          if (recv_roll < 15)
            stall_left = $urandom_range(1, 3);
          else if (recv_roll < 18)
            stall_left = $urandom_range(8, 40);
        end
      end
    end
  end

  // ------------------------------------------------------------ run control

  initial begin
    int          total;
    int          k;
    logic [15:0] pg;
    rst = 1'b1;
    packets.valid = 1'b0;
    packets.packet_word0 = '0;
    packets.packet_word1 = '0;
    packets.packet_word2 = '0;
    packets.packet_word3 = '0;
    results.ready = 1'b0;

    // stray data and foreign header types while idle
    pending_packets.push_back(random_packet());
    pending_packets.push_back(header_packet(8'd0, 16'($urandom), 8'($urandom),
                                            8'($urandom), 16'($urandom)));
    pending_packets.push_back(header_packet(8'd3, 16'($urandom), 8'($urandom),
                                            8'($urandom), 16'($urandom)));
    pending_packets.push_back(header_packet(8'hFF, 16'($urandom), 8'($urandom),
                                            8'($urandom), 16'($urandom)));
    send_text(16'd0, 8'd9, 1);
    send_text(16'd1, 8'd0, 1);
    send_text(16'd2, 8'd33, 2);
    send_text(16'd1, 8'd1, 1);
    // all-zero and all-one payload bytes
    send_text(16'd2, 8'd32, 0);
    pending_packets.push_back('0);
    pending_packets.push_back('1);
    // file without pages: data after the name is dropped
    send_file(16'd0, 8'd5, 8'd1, 1'b1, 1);
    send_file(16'd2, 8'd31, 8'd32, 1'b1, 2);
    send_file(16'd1, 8'd32, 8'd33, 1'b0, 1);

    // name that never completes, long enough to saturate the name counter
    send_file(16'd1, pick_tail(), 8'd0, 1'b1, 18);
    seq_items = pending_packets.size();
    while (seq_items < 160) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          pg = 16'($urandom_range(0, 3));
          send_text(pg, pick_tail(), (pg == 16'd0) ? 1 : int'(pg));
        end
        3, 4, 5: begin
          pg = 16'($urandom_range(0, 3));
          send_file(pg, pick_tail(), 8'($urandom_range(1, 40)), 1'($urandom_range(0, 1)),
                    int'(pg));
        end
        6: begin
          // huge page count cut short by the next header
          if ($urandom_range(0, 1) == 1)
            send_text(16'($urandom), pick_tail(), $urandom_range(0, 2));
          else
            send_file(16'($urandom), pick_tail(), 8'($urandom_range(1, 70)), 1'b1,
                      $urandom_range(0, 2));
        end
        7: begin
          pending_packets.push_back(random_packet());
          pending_packets.push_back(header_packet(8'($urandom_range(3, 255)),
                                                  16'($urandom), 8'($urandom),
                                                  8'($urandom), 16'($urandom)));
          // one bit off the marker makes it a data packet
          next_packet = random_packet();
          next_packet[63:0] = SYNC_MARK ^ (64'd1 << $urandom_range(0, 63));
          pending_packets.push_back(next_packet);
          seq_items += 3;
        end
        8: begin
          pg = 16'($urandom_range(1, 2));
          send_file(pg, pick_tail(), 8'($urandom_range(41, 255)), 1'($urandom_range(0, 1)),
                    int'(pg));
        end
        default: begin
          // header interrupted partway through a file or a text
          if ($urandom_range(0, 1) == 1)
            send_file(16'd2, pick_tail(), 8'($urandom_range(33, 100)), 1'b1, 0);
          else
            send_text(16'd3, pick_tail(), 1);
        end
      endcase
    end
    total = pending_packets.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (rst || packets_accepted < total)
      @(posedge clk);
    for (k = 0; k < 200000 && expected_bytes.size() != 0; k++)
      @(posedge clk);
    repeat (64) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results missing, expected kind=%0d value=%02h, got nothing",
               $time, expected_bytes.size(), expected_bytes[0].kind,
               expected_bytes[0].value);
    end
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
